>>> rtl/core/lru_frame_replacer_core_assert.svh
// Assertion macros shared by the frame replacer RTL.
`ifndef LRU_FRAME_REPLACER_CORE_ASSERT_SVH
`define LRU_FRAME_REPLACER_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define LFR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define LFR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/lfr_pkg.sv
// Shared types, codes and helpers for the LRU frame replacer.
`timescale 1ns / 1ps
package lfr_pkg;

    localparam int MAX_FRAMES_DEF = 16;
    localparam int ID_BITS_DEF    = 8;

    localparam int MODE_W  = 2;
    localparam int FRAME_W = 8;
    localparam int CAP_W   = 5;
    localparam int DATA_W  = 32;
    localparam int PADDR_W = 3;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Register index, taken from the word address bits of paddr.
    localparam logic [PADDR_W-3:0] REG_CAPACITY = 1'b0;

    localparam logic [MODE_W-1:0] MODE_VICTIM = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PIN    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_UNPIN  = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXE  = 2'b10
    } t_state;

    typedef struct packed {
        logic cmp;
        logic occupied;
        logic take_left;
        logic take_right;
    } t_cell_ctl;

    typedef struct packed {
        logic             wr;
        logic [CAP_W-1:0] value;
    } t_cfg_evt;

    typedef struct packed {
        logic               found;
        logic [FRAME_W-1:0] victim_frame;
        logic               dropped;
        logic [FRAME_W-1:0] dropped_frame;
        logic [CAP_W-1:0]   evictable_count;
    } t_rsp;

    // Capacity as used: zero counts as one, and it never exceeds the cell count.
    function automatic logic [CAP_W-1:0] eff_cap(input logic [CAP_W-1:0] cap,
                                                 input int max_frames);
        logic [CAP_W-1:0] c;
        c = cap;
        if (c == '0) begin
            c = CAP_W'(1);
        end else if (int'(c) > max_frames) begin
            c = CAP_W'(max_frames);
        end
        return c;
    endfunction

endpackage

>>> rtl/core/lfr_req_if.sv
// Request channel interface: valid/ready with mode and frame id.
`timescale 1ns / 1ps
interface lfr_req_if;
    import lfr_pkg::*;

    logic               valid;
    logic               ready;
    logic [MODE_W-1:0]  mode;
    logic [FRAME_W-1:0] frame_num;

    modport source (output valid, output mode, output frame_num, input ready);
    modport sink   (input valid, input mode, input frame_num, output ready);
endinterface

>>> rtl/core/lfr_rsp_if.sv
// Result channel interface: valid/ready with victim, drop and count fields.
`timescale 1ns / 1ps
interface lfr_rsp_if;
    import lfr_pkg::*;

    logic               valid;
    logic               ready;
    logic               found;
    logic [FRAME_W-1:0] victim_frame;
    logic               dropped;
    logic [FRAME_W-1:0] dropped_frame;
    logic [CAP_W-1:0]   evictable_count;

    modport source (output valid, output found, output victim_frame, output dropped,
                    output dropped_frame, output evictable_count, input ready);
    modport sink   (input valid, input found, input victim_frame, input dropped,
                    input dropped_frame, input evictable_count, output ready);
endinterface

>>> rtl/core/lfr_cell.sv
// One recency cell: holds a frame id, compares it and shifts with its neighbors.
`timescale 1ns / 1ps
module lfr_cell #(
    parameter int ID_BITS = lfr_pkg::ID_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lfr_pkg::t_cell_ctl i_ctl,
    input  logic [ID_BITS-1:0] i_key,
    input  logic [ID_BITS-1:0] i_left_id,
    input  logic [ID_BITS-1:0] i_right_id,
    output logic [ID_BITS-1:0] o_id,
    output logic               o_match
);
    import lfr_pkg::*;

    logic [ID_BITS-1:0] r_id;
    logic [ID_BITS-1:0] n_id;
    logic               r_match;
    logic               n_match;

    // Moving toward the old end takes the newer neighbor; closing a gap takes the older one.
    always_comb begin
        n_id = r_id;
        if (i_ctl.take_left) begin
            n_id = i_left_id;
        end else if (i_ctl.take_right) begin
            n_id = i_right_id;
        end
    end

    always_comb begin
        n_match = r_match;
        if (i_ctl.cmp) begin
            n_match = i_ctl.occupied && (r_id == i_key);
        end
    end

    always_ff @(posedge i_clk) begin
        r_id <= n_id;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else begin
            r_match <= n_match;
        end
    end

    assign o_id    = r_id;
    assign o_match = r_match;

endmodule

>>> rtl/core/lfr_apb.sv
// Configuration register file behind an APB-style port.
`timescale 1ns / 1ps
module lfr_apb (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lfr_pkg::PADDR_W-1:0]   paddr,
    input  logic [lfr_pkg::DATA_W-1:0]    pwdata,
    output logic [lfr_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    output logic [lfr_pkg::CAP_W-1:0]     o_cap,
    output lfr_pkg::t_cfg_evt             o_evt
);
    import lfr_pkg::*;

    logic [CAP_W-1:0] r_cap;
    logic             w_sel_cap;

    assign pready    = 1'b1;
    assign w_sel_cap = (paddr[PADDR_W-1:2] == REG_CAPACITY);

    assign o_evt.wr    = psel && penable && pwrite && pready && w_sel_cap;
    assign o_evt.value = pwdata[CAP_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (o_evt.wr) begin
            r_cap <= o_evt.value;
        end
    end

    assign prdata = w_sel_cap ? {{(DATA_W-CAP_W){1'b0}}, r_cap} : '0;
    assign o_cap  = r_cap;

endmodule

>>> rtl/core/lru_frame_replacer_core.sv
// Top level of the LRU frame replacer: a row of recency cells with a small sequencer.
//
// Requests arrive on i_req (valid/ready) with a mode and a frame id: victim takes the
// oldest held frame out, pin removes the named frame if held, unpin adds an absent frame
// as the newest and, on a full set, first drops the oldest one and reports it. Every
// item gives exactly one result on o_rsp, which also carries the count held afterwards.
// The capacity register sits on the APB-style port at address 0 and must be written
// only while the block is idle; the block itself does not enforce this. Lowering it
// below the held count discards the oldest frames. At the accept edge every cell
// compares its id with the key and registers the match; in the update state, once
// the output register is free, the row shifts in one step and the result is
// registered. No new item is taken until the block is back in idle.
// A result waiting in the output register does not block acceptance of the next item;
// that item then waits in its update cycle until the receiver takes the older result.
// Reset (i_rst_n low, synchronous) empties the set, clears the capacity to 16 and
// drops any pending result; the stored ids themselves are not cleared.
`timescale 1ns / 1ps
module lru_frame_replacer_core #(
    parameter int MAX_FRAMES = lfr_pkg::MAX_FRAMES_DEF,
    parameter int ID_BITS    = lfr_pkg::ID_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lfr_pkg::PADDR_W-1:0] paddr,
    input  logic [lfr_pkg::DATA_W-1:0]  pwdata,
    output logic [lfr_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    lfr_req_if.sink                     i_req,
    lfr_rsp_if.source                   o_rsp
);
    import lfr_pkg::*;

`include "lru_frame_replacer_core_assert.svh"

    // The count can reach MAX_FRAMES, so it needs one value more than the cell index.
    localparam int CW = $clog2(MAX_FRAMES + 1);

    t_state              r_state;
    t_state              n_state;
    logic [MODE_W-1:0]   r_mode;
    logic [ID_BITS-1:0]  r_key;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    t_rsp                r_out;
    t_rsp                n_out;
    logic                r_out_valid;

    logic [CAP_W-1:0]    w_cap;
    t_cfg_evt            w_cfg;
    logic [CW-1:0]       w_eff_cap;
    logic [CW-1:0]       w_new_eff_cap;

    logic                w_acc;
    logic                w_commit;
    logic                w_any;
    logic                w_shift_in;
    logic                w_shift_out;
    logic [ID_BITS-1:0]  w_in_key;
    logic [ID_BITS-1:0]  w_oldest;
    logic [FRAME_W-1:0]  w_oldest_frame;

    logic [ID_BITS-1:0]  w_ids [MAX_FRAMES];
    t_cell_ctl           w_ctl [MAX_FRAMES];
    logic [MAX_FRAMES-1:0] w_match;
    logic [MAX_FRAMES-1:0] w_after;
    logic [MAX_FRAMES-1:0] w_occ;
    logic [MAX_FRAMES-1:0] w_last;

    lfr_apb u_apb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cap   (w_cap),
        .o_evt   (w_cfg)
    );

    assign w_eff_cap     = CW'(eff_cap(w_cap, MAX_FRAMES));
    assign w_new_eff_cap = CW'(eff_cap(w_cfg.value, MAX_FRAMES));

    // Frame ids map onto ID_BITS-wide cell ids: extra bits are dropped or zero-filled.
    for (genvar b = 0; b < ID_BITS; b++) begin : g_key_bit
        if (b < FRAME_W) begin : g_used
            assign w_in_key[b] = i_req.frame_num[b];
        end else begin : g_pad
            assign w_in_key[b] = 1'b0;
        end
    end

    for (genvar b = 0; b < FRAME_W; b++) begin : g_out_bit
        if (b < ID_BITS) begin : g_used
            assign w_oldest_frame[b] = w_oldest[b];
        end else begin : g_pad
            assign w_oldest_frame[b] = 1'b0;
        end
    end

    // Sequencer: the accept edge launches the compare, the update cycle commits the
    // shift and the result once the output register is free.
    assign i_req.ready = (r_state == S_IDLE);
    assign w_acc       = i_req.valid && i_req.ready;
    assign w_commit    = (r_state == S_EXE) && (!r_out_valid || o_rsp.ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_state = S_EXE;
                end
            end
            S_EXE: begin
                if (w_commit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Entry 0 is the newest; a held frame appears in at most one occupied cell.
    assign w_any       = |w_match;
    assign w_shift_in  = w_commit && (r_mode == MODE_UNPIN) && !w_any;
    assign w_shift_out = w_commit && (r_mode == MODE_PIN) && w_any;

    for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
        logic [ID_BITS-1:0] w_left;
        logic [ID_BITS-1:0] w_right;

        assign w_occ[i]   = CW'(i) < r_count;
        assign w_last[i]  = (r_count == CW'(i + 1));
        // Cells at or past the pinned frame close the gap by taking the older neighbor.
        assign w_after[i] = |w_match[i:0];

        if (i == 0) begin : g_head
            assign w_left = r_key;
        end else begin : g_body
            assign w_left = w_ids[i-1];
        end

        if (i == MAX_FRAMES - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_inner
            assign w_right = w_ids[i+1];
        end

        assign w_ctl[i] = '{cmp:        w_acc,
                            occupied:   w_occ[i],
                            take_left:  w_shift_in,
                            take_right: w_shift_out && w_after[i]};

        lfr_cell #(
            .ID_BITS (ID_BITS)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl[i]),
            .i_key      (w_in_key),
            .i_left_id  (w_left),
            .i_right_id (w_right),
            .o_id       (w_ids[i]),
            .o_match    (w_match[i])
        );
    end

    // The oldest held frame sits in the cell just below the count.
    always_comb begin
        w_oldest = '0;
        for (int i = 0; i < MAX_FRAMES; i++) begin
            w_oldest = w_oldest | (w_ids[i] & {ID_BITS{w_last[i]}});
        end
    end

    always_comb begin
        n_count = r_count;
        n_out   = '0;
        unique case (r_mode)
            MODE_VICTIM: begin
                if (r_count != '0) begin
                    n_out.found        = 1'b1;
                    n_out.victim_frame = w_oldest_frame;
                    n_count            = r_count - CW'(1);
                end
            end
            MODE_PIN: begin
                if (w_any) begin
                    n_count = r_count - CW'(1);
                end
            end
            MODE_UNPIN: begin
                if (!w_any) begin
                    // A full set loses its oldest frame, which leaves the count unchanged.
                    if (r_count >= w_eff_cap) begin
                        n_out.dropped       = 1'b1;
                        n_out.dropped_frame = w_oldest_frame;
                    end else begin
                        n_count = r_count + CW'(1);
                    end
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
        n_out.evictable_count = CAP_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_commit) begin
                r_count <= n_count;
            end else if (w_cfg.wr && (r_count > w_new_eff_cap)) begin
                r_count <= w_new_eff_cap;
            end
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_mode <= i_req.mode;
            r_key  <= w_in_key;
        end
        if (w_commit) begin
            r_out <= n_out;
        end
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.found           = r_out.found;
    assign o_rsp.victim_frame    = r_out.victim_frame;
    assign o_rsp.dropped         = r_out.dropped;
    assign o_rsp.dropped_frame   = r_out.dropped_frame;
    assign o_rsp.evictable_count = r_out.evictable_count;

    `LFR_ASSERT_IMP(a_count_within_cap, 1'b1, r_count <= w_eff_cap, "held count exceeds capacity")
    `LFR_ASSERT_IMP(a_match_unique, r_state == S_EXE, $onehot0(w_match), "frame held twice")
    `LFR_ASSERT_NXT(a_accept_to_update, w_acc, r_state == S_EXE, "accepted item not in update")

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for the LRU frame replacer: directed script, then random traffic.
`timescale 1ns / 1ps
module tb_top;
    import lfr_pkg::*;

    // Clock half period in ns, giving the 20 ns period.
    localparam int CLK_HALF    = 10;
    // Watchdog limit; the slowest correct run stays far below it.
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 210;
    localparam int POOL_SIZE   = 20;
    localparam int REPORT_MAX  = 10;
    localparam int SET_SIZE    = MAX_FRAMES_DEF;
    // Mode 3 is not a defined request kind; the block must answer it without any change.
    localparam logic [MODE_W-1:0]  MODE_UNKNOWN = 2'd3;
    localparam logic [PADDR_W-1:0] CAP_ADDR     = {REG_CAPACITY, 2'b00};

    typedef enum logic { ROW_ITEM, ROW_CFG } t_row_kind;

    // One line of the directed script: either a capacity write or a request. A request may
    // carry a hand-written result; otherwise the recency tracker below supplies it.
    typedef struct {
        t_row_kind          kind;
        logic [CAP_W-1:0]   cap;
        logic [MODE_W-1:0]  mode;
        logic [FRAME_W-1:0] id;
        logic               typed;
        t_rsp               want;
    } t_script_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    lfr_req_if req_bus ();
    lfr_rsp_if rsp_bus ();

    lru_frame_replacer_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    // Shadow of the recency set: entry 0 is the newest frame, entry lru_count-1 the oldest.
    logic [FRAME_W-1:0] lru_ids [SET_SIZE];
    int                 lru_count;
    logic [CAP_W-1:0]   cap_shadow;

    // Results still owed by the block, oldest first.
    t_rsp        owed_results [$];
    t_script_row script [$];
    int          mismatches;
    int          send_idle_pct;
    int          stall_pct;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // The capacity register as the set actually uses it: zero acts as one, and anything
    // above the number of cells acts as the number of cells.
    function automatic int frames_allowed();
        int c;
        c = int'(cap_shadow);
        if (c == 0) begin
            c = 1;
        end
        if (c > SET_SIZE) begin
            c = SET_SIZE;
        end
        return c;
    endfunction

    // Applies one request to the shadow set and returns the result the block owes for it.
    function automatic t_rsp apply_request(input logic [MODE_W-1:0] mode,
                                           input logic [FRAME_W-1:0] id);
        t_rsp r;
        int   pos;
        int   i;
        r   = '0;
        pos = lru_count;
        for (i = 0; i < lru_count; i++) begin
            if (pos == lru_count && lru_ids[i] == id) begin
                pos = i;
            end
        end
        case (mode)
            MODE_VICTIM: begin
                if (lru_count > 0) begin
                    r.found        = 1'b1;
                    r.victim_frame = lru_ids[lru_count-1];
                    lru_count--;
                end
            end
            MODE_PIN: begin
                if (pos < lru_count) begin
                    for (i = pos; i + 1 < lru_count; i++) begin
                        lru_ids[i] = lru_ids[i+1];
                    end
                    lru_count--;
                end
            end
            MODE_UNPIN: begin
                // A frame already held keeps its place; only an absent one is inserted.
                if (pos == lru_count) begin
                    if (lru_count >= frames_allowed()) begin
                        r.dropped       = 1'b1;
                        r.dropped_frame = lru_ids[lru_count-1];
                        lru_count--;
                    end
                    for (i = lru_count; i > 0; i--) begin
                        lru_ids[i] = lru_ids[i-1];
                    end
                    lru_ids[0] = id;
                    lru_count++;
                end
            end
            default: begin
            end
        endcase
        r.evictable_count = CAP_W'(lru_count);
        return r;
    endfunction

    function automatic t_script_row req_row(input logic [MODE_W-1:0] mode,
                                            input logic [FRAME_W-1:0] id);
        t_script_row row;
        row.kind  = ROW_ITEM;
        row.cap   = '0;
        row.mode  = mode;
        row.id    = id;
        row.typed = 1'b0;
        row.want  = '0;
        return row;
    endfunction

    function automatic t_script_row known_row(input logic [MODE_W-1:0] mode,
                                              input logic [FRAME_W-1:0] id,
                                              input logic found,
                                              input logic [FRAME_W-1:0] victim,
                                              input logic dropped,
                                              input logic [FRAME_W-1:0] dropped_id,
                                              input logic [CAP_W-1:0] count);
        t_script_row row;
        row = req_row(mode, id);
        row.typed                = 1'b1;
        row.want.found           = found;
        row.want.victim_frame    = victim;
        row.want.dropped         = dropped;
        row.want.dropped_frame   = dropped_id;
        row.want.evictable_count = count;
        return row;
    endfunction

    function automatic t_script_row cap_row(input logic [CAP_W-1:0] cap);
        t_script_row row;
        row      = req_row(MODE_VICTIM, '0);
        row.kind = ROW_CFG;
        row.cap  = cap;
        return row;
    endfunction

    // Offers one item, possibly after a random gap, and records the owed result at the
    // edge where the block takes it. valid stays high afterwards so that back-to-back
    // items follow without a gap in valid; settle() lowers it when the stream pauses.
    task automatic send_item(input logic [MODE_W-1:0] mode, input logic [FRAME_W-1:0] id,
                             input logic typed, input t_rsp want);
        t_rsp got;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            req_bus.valid     <= 1'b0;
            req_bus.mode      <= MODE_W'($urandom_range(0, 3));
            req_bus.frame_num <= FRAME_W'($urandom_range(0, 255));
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        req_bus.valid     <= 1'b1;
        req_bus.mode      <= mode;
        req_bus.frame_num <= id;
        do @(posedge i_clk); while (!req_bus.ready);
        got = apply_request(mode, id);
        owed_results.push_back(typed ? want : got);
    endtask

    // Stops offering items and waits until every owed result has come back. Since each
    // item yields a result, an empty list means the block is idle.
    task automatic settle();
        req_bus.valid <= 1'b0;
        do @(posedge i_clk); while (owed_results.size() != 0);
    endtask

    // Register write: setup phase, then access phase; the write lands when pready is seen.
    task automatic write_capacity(input logic [CAP_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CAP_ADDR;
        pwdata  <= DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        // Lowering the capacity silently discards the oldest frames beyond it.
        cap_shadow = value;
        if (lru_count > frames_allowed()) begin
            lru_count = frames_allowed();
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Receiver: ready is redrawn every cycle from the stall rate of the current phase.
    initial begin
        rsp_bus.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            rsp_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Result checker: every accepted result is matched against the oldest owed result.
    always @(posedge i_clk) begin
        t_rsp seen;
        t_rsp want;
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
            seen.found           = rsp_bus.found;
            seen.victim_frame    = rsp_bus.victim_frame;
            seen.dropped         = rsp_bus.dropped;
            seen.dropped_frame   = rsp_bus.dropped_frame;
            seen.evictable_count = rsp_bus.evictable_count;
            if (owed_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("%0t: unowed result found=%0d vic=%0h drop=%0d dfr=%0h cnt=%0d",
                             $realtime, seen.found, seen.victim_frame, seen.dropped,
                             seen.dropped_frame, seen.evictable_count);
                end
            end else begin
                want = owed_results[0];
                owed_results.delete(0);
                if (seen.found !== want.found || seen.victim_frame !== want.victim_frame ||
                    seen.dropped !== want.dropped || seen.dropped_frame !== want.dropped_frame ||
                    seen.evictable_count !== want.evictable_count) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX) begin
                        $display("%0t: expected found=%0d vic=%0h drop=%0d dfr=%0h cnt=%0d",
                                 $realtime, want.found, want.victim_frame, want.dropped,
                                 want.dropped_frame, want.evictable_count);
                        $display("%0t:      got found=%0d vic=%0h drop=%0d dfr=%0h cnt=%0d",
                                 $realtime, seen.found, seen.victim_frame, seen.dropped,
                                 seen.dropped_frame, seen.evictable_count);
                    end
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("lru_frame_replacer_core regression: fail");
        $finish;
    end

    initial begin
        logic [FRAME_W-1:0] id_pool [POOL_SIZE];
        logic [CAP_W-1:0]   phase_cap;
        logic [MODE_W-1:0]  mode;
        logic [FRAME_W-1:0] id;
        int                 pick;
        int                 k;

        i_rst_n           = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        req_bus.valid     = 1'b0;
        req_bus.mode      = MODE_VICTIM;
        req_bus.frame_num = '0;
        send_idle_pct     = 0;
        stall_pct         = 0;
        mismatches        = 0;

        // Directed script. Right after reset the capacity is 16 and the set is empty.
        script.push_back(known_row(MODE_VICTIM, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00, 5'd0));
        script.push_back(known_row(MODE_PIN, 8'hFF, 1'b0, 8'h00, 1'b0, 8'h00, 5'd0));
        script.push_back(known_row(MODE_UNPIN, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00, 5'd1));
        script.push_back(known_row(MODE_UNPIN, 8'hFF, 1'b0, 8'h00, 1'b0, 8'h00, 5'd2));
        // Unpinning a frame already held changes nothing.
        script.push_back(known_row(MODE_UNPIN, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00, 5'd2));
        script.push_back(known_row(MODE_UNKNOWN, 8'hAA, 1'b0, 8'h00, 1'b0, 8'h00, 5'd2));
        // The victim is the frame unpinned first, and the frame id on the request is ignored.
        script.push_back(known_row(MODE_VICTIM, 8'hFF, 1'b1, 8'h00, 1'b0, 8'h00, 5'd1));
        script.push_back(req_row(MODE_UNPIN, 8'h55));
        script.push_back(req_row(MODE_UNPIN, 8'hAA));
        // Pin from the middle of the order, then pin the same frame once it is gone.
        script.push_back(req_row(MODE_PIN, 8'h55));
        script.push_back(req_row(MODE_PIN, 8'h55));
        script.push_back(req_row(MODE_VICTIM, 8'h3C));
        script.push_back(cap_row(5'd2));
        script.push_back(req_row(MODE_UNPIN, 8'h01));
        // Set full at capacity two: the oldest frame makes room and is reported.
        script.push_back(known_row(MODE_UNPIN, 8'h80, 1'b0, 8'h00, 1'b1, 8'hAA, 5'd2));
        script.push_back(req_row(MODE_UNPIN, 8'h01));
        // Capacity zero acts as one and trims the set down to its newest frame.
        script.push_back(cap_row(5'd0));
        script.push_back(known_row(MODE_UNPIN, 8'h7F, 1'b0, 8'h00, 1'b1, 8'h80, 5'd1));
        script.push_back(known_row(MODE_VICTIM, 8'h00, 1'b1, 8'h7F, 1'b0, 8'h00, 5'd0));
        script.push_back(known_row(MODE_VICTIM, 8'hFF, 1'b0, 8'h00, 1'b0, 8'h00, 5'd0));
        // Capacity above the cell count acts as the cell count.
        script.push_back(cap_row(5'd31));
        script.push_back(req_row(MODE_UNPIN, 8'hFE));
        script.push_back(req_row(MODE_UNPIN, 8'h00));
        script.push_back(req_row(MODE_PIN, 8'hFE));
        script.push_back(req_row(MODE_VICTIM, 8'h00));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (k = 0; k < SET_SIZE; k++) begin
            lru_ids[k] = '0;
        end
        lru_count  = 0;
        cap_shadow = CAP_RESET;
        @(posedge i_clk);

        for (k = 0; k < script.size(); k++) begin
            if (script[k].kind == ROW_CFG) begin
                settle();
                write_capacity(script[k].cap);
            end else begin
                send_item(script[k].mode, script[k].id, script[k].typed, script[k].want);
            end
        end

        // Random phases. Each one settles, picks a new capacity (the write often lands on
        // a well-filled set, so trimming gets exercised) and an idling pattern, then runs
        // a request mix biased toward unpin so the set fills and overflows regularly.
        for (k = 0; k < PHASES; k++) begin
            settle();
            case (k % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 83; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 83; end
                default: begin send_idle_pct = 19; stall_pct = 19; end
            endcase
            case (k)
                0: phase_cap = 5'd1;
                1: phase_cap = CAP_RESET;
                2: phase_cap = 5'd0;
                3: phase_cap = 5'd31;
                4: phase_cap = 5'd3;
                6: phase_cap = 5'd8;
                default: phase_cap = CAP_W'($urandom_range(0, 31));
            endcase
            write_capacity(phase_cap);
            // A small pool of ids per phase keeps pins and repeated unpins hitting held frames.
            for (pick = 0; pick < POOL_SIZE; pick++) begin
                id_pool[pick] = FRAME_W'($urandom_range(0, 255));
            end
            repeat (PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 50) begin
                    mode = MODE_UNPIN;
                end else if (pick < 70) begin
                    mode = MODE_PIN;
                end else if (pick < 95) begin
                    mode = MODE_VICTIM;
                end else begin
                    mode = MODE_UNKNOWN;
                end
                if ($urandom_range(0, 99) < 85) begin
                    id = id_pool[$urandom_range(0, POOL_SIZE-1)];
                end else begin
                    id = FRAME_W'($urandom_range(0, 255));
                end
                send_item(mode, id, 1'b0, '0);
            end
        end

        settle();
        // Idle the bus before the verdict so that any stray extra result is caught by the checker.
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("lru_frame_replacer_core regression: pass");
        end else begin
            $display("lru_frame_replacer_core regression: fail");
        end
        $finish;
    end

endmodule
